// ===== rtl/core/frapk_pkg.sv =====
// ----------------------------------------------------------------------------
// frapk_pkg
// Shared types, constants and float-to-byte helpers of the RGBA packer.
// ----------------------------------------------------------------------------
package frapk_pkg;

    localparam int DIM_W  = 13;
    localparam int DVD_W  = 2 * DIM_W;
    localparam int ROW_W  = 12;
    localparam int BYTE_W = 8;
    localparam int CIDX_W = 2;

    typedef enum logic [CIDX_W-1:0] {
        CFG_SRC_W,
        CFG_SRC_H,
        CFG_DST_W,
        CFG_DST_H
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COL_GO,
        ST_COL_WAIT,
        ST_ROW_MUL,
        ST_ROW_GO,
        ST_ROW_WAIT
    } t_state;

    typedef enum logic {
        DIV_COL,
        DIV_ROW
    } t_div_sel;

    typedef enum logic [1:0] {
        CV_ZERO,
        CV_FULL,
        CV_SCALE
    } t_cv_kind;

    typedef struct packed {
        t_cv_kind    kind;
        logic [32:0] sig;
        logic [7:0]  sh;
    } t_cvt;

    typedef struct packed {
        logic     take_load;
        logic     take_pixel;
        logic     div_start;
        t_div_sel div_sel;
        logic     col_apply;
        logic     row_mul;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic row_end_now;
        logic div_busy;
        logic out_free;
    } t_sts;

    // value*255 rounded to single precision, kept as an integer significand
    function automatic t_cvt cvt_scale(input logic [31:0] b);
        t_cvt        c;
        logic [7:0]  e;
        logic [31:0] m;
        logic [31:0] x;
        logic [24:0] keep;
        logic [7:0]  lo;
        logic        rup;
        e      = b[30:23];
        m      = {8'd0, 1'b1, b[22:0]};
        x      = (m << 8) - m;
        c.kind = CV_SCALE;
        c.sig  = '0;
        c.sh   = 8'd0;
        if (b[31] || e == 8'd0 || (e == 8'hFF && b[22:0] != 23'd0)) begin
            c.kind = CV_ZERO;
        end else if (e >= 8'd127) begin
            c.kind = CV_FULL;
        end else begin
            c.sh = 8'd126 - e;
            if (x[31]) begin
                keep  = {1'b0, x[31:8]};
                lo    = x[7:0];
                rup   = (lo > 8'h80) || (lo == 8'h80 && keep[0]);
                keep  = keep + {24'd0, rup};
                c.sig = {keep, 8'd0};
            end else begin
                keep  = {1'b0, x[30:7]};
                lo    = {1'b0, x[6:0]};
                rup   = (lo > 8'h40) || (lo == 8'h40 && keep[0]);
                keep  = keep + {24'd0, rup};
                c.sig = {1'b0, keep, 7'd0};
            end
        end
        return c;
    endfunction

    // add one half in single precision, then truncate to a byte
    function automatic logic [7:0] cvt_round(input t_cvt c);
        logic [34:0] t;
        logic [34:0] y;
        logic [34:0] mask;
        logic [34:0] low;
        logic [34:0] half;
        logic [34:0] keep;
        logic [34:0] r;
        logic [5:0]  q;
        logic [7:0]  res;
        t = {c.sig, 2'b00} >> c.sh;
        y = t + 35'h2000000;
        q = 6'd2;
        for (int k = 26; k < 35; k++) begin
            if (y[k]) begin
                q = 6'(k - 23);
            end
        end
        mask = (35'd1 << q) - 35'd1;
        low  = y & mask;
        half = 35'd1 << (q - 6'd1);
        keep = y >> q;
        if (low > half || (low == half && keep[0])) begin
            keep = keep + 35'd1;
        end
        r = keep << q;
        case (c.kind)
            CV_ZERO: res = 8'd0;
            CV_FULL: res = 8'hFF;
            default: res = r[33:26];
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/core/frapk_div.sv =====
// ----------------------------------------------------------------------------
// frapk_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frapk_div
    import frapk_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dvd,
    input  logic [DIM_W-1:0] i_dvr,
    output logic             o_busy,
    output logic [DVD_W-1:0] o_quo,
    output logic [DIM_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DIM_W-1:0] r_rem;
    logic [DIM_W-1:0] r_dvr;
    logic [DIM_W:0]   rem_sh;
    logic [DIM_W:0]   diff;
    logic             ge;

    assign rem_sh = {r_rem, r_quo[DVD_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dvr};
    assign diff   = rem_sh - {1'b0, r_dvr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(DVD_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dvd;
            r_rem <= '0;
            r_dvr <= i_dvr;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DVD_W-2:0], ge};
            r_rem <= ge ? diff[DIM_W-1:0] : rem_sh[DIM_W-1:0];
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/core/frapk_dp.sv =====
// ----------------------------------------------------------------------------
// frapk_dp
// Datapath: size registers, counters, alpha row memory, divider, converters
// and the output register.
// ----------------------------------------------------------------------------
module frapk_dp
    import frapk_pkg::*;
#(
    parameter int MAX_DIM = 4096
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [BYTE_W-1:0] i_alpha_byte,
    input  logic [31:0]       i_red_bits,
    input  logic [31:0]       i_green_bits,
    input  logic [31:0]       i_blue_bits,
    input  logic              i_cfg_valid,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]  i_cfg_data,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_red_byte,
    output logic [BYTE_W-1:0] o_green_byte,
    output logic [BYTE_W-1:0] o_blue_byte,
    output logic [BYTE_W-1:0] o_alpha_out,
    output logic              o_row_end,
    output logic              o_frame_end,
    output logic [ROW_W-1:0]  o_next_input_row
);

    localparam int AW   = $clog2(MAX_DIM);
    localparam int MAXC = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
    localparam logic [DIM_W-1:0] MAXV = DIM_W'(MAXC);

    function automatic logic [AW-1:0] to_idx(input logic [DIM_W-1:0] c);
        logic [AW+DIM_W-1:0] w;
        w = {{AW{1'b0}}, c};
        return w[AW-1:0];
    endfunction

    logic [DIM_W-1:0]  r_sw, r_sh, r_tw, r_th;
    logic [DIM_W-1:0]  r_lc, r_oc, r_or, r_sc, r_acc;
    logic              r_ovalid;
    logic [BYTE_W-1:0] mem [MAX_DIM];
    logic [BYTE_W-1:0] r_alpha;
    logic              r_row_end, r_frame_end;
    t_cvt              r_cv_r, r_cv_g, r_cv_b;
    logic [BYTE_W-1:0] r_by_r, r_by_g, r_by_b;
    logic [DVD_W-1:0]  r_prod;
    logic [BYTE_W-1:0] r_o_r, r_o_g, r_o_b, r_o_a;
    logic              r_o_re, r_o_fe;
    logic [ROW_W-1:0]  r_o_nir;

    logic [DIM_W-1:0]  sw_m1, sh_m1, tw_m1, th_m1;
    logic [DIM_W-1:0]  ld_col, ld_next, rd_col, sc_next, cfg_val;
    logic [DIM_W:0]    ld_inc, acc_sum;
    logic [DVD_W:0]    sc_sum;
    logic [DVD_W-1:0]  nir_full;
    logic              row_end_now, frame_now, out_free;
    logic [DVD_W-1:0]  div_dvd;
    logic [DIM_W-1:0]  div_dvr;
    logic              div_busy;
    logic [DVD_W-1:0]  div_quo;
    logic [DIM_W-1:0]  div_rem;

    assign sw_m1 = r_sw - 1'b1;
    assign sh_m1 = r_sh - 1'b1;
    assign tw_m1 = r_tw - 1'b1;
    assign th_m1 = r_th - 1'b1;

    assign ld_col  = (r_lc < sw_m1) ? r_lc : sw_m1;
    assign ld_inc  = {1'b0, ld_col} + 1'b1;
    assign ld_next = (ld_inc < {1'b0, sw_m1}) ? ld_inc[DIM_W-1:0] : sw_m1;
    assign rd_col  = (r_sc < sw_m1) ? r_sc : sw_m1;

    assign row_end_now = r_oc >= tw_m1;
    assign frame_now   = row_end_now && (r_or >= th_m1);
    assign acc_sum     = {1'b0, r_acc} + {1'b0, r_sw};

    assign div_dvd = (i_cmd.div_sel == DIV_ROW) ? r_prod
                                                : {{(DVD_W-DIM_W-1){1'b0}}, acc_sum};
    assign div_dvr = (i_cmd.div_sel == DIV_ROW) ? r_th : r_tw;

    assign sc_sum  = {1'b0, div_quo} + {{(DVD_W-DIM_W+1){1'b0}}, r_sc};
    assign sc_next = (sc_sum < {{(DVD_W-DIM_W+1){1'b0}}, sw_m1}) ? sc_sum[DIM_W-1:0] : sw_m1;
    assign nir_full = (div_quo < {{(DVD_W-DIM_W){1'b0}}, sh_m1}) ? div_quo
                                                              : {{(DVD_W-DIM_W){1'b0}}, sh_m1};

    assign cfg_val = (i_cfg_data == '0) ? DIM_W'(1)
                   : ((i_cfg_data > MAXV) ? MAXV : i_cfg_data);

    assign out_free = !r_ovalid || !i_stall;

    frapk_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_dvd   (div_dvd),
        .i_dvr   (div_dvr),
        .o_busy  (div_busy),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw     <= DIM_W'(1);
            r_sh     <= DIM_W'(1);
            r_tw     <= DIM_W'(1);
            r_th     <= DIM_W'(1);
            r_lc     <= '0;
            r_oc     <= '0;
            r_or     <= '0;
            r_sc     <= '0;
            r_acc    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SRC_W: r_sw <= cfg_val;
                    CFG_SRC_H: r_sh <= cfg_val;
                    CFG_DST_W: r_tw <= cfg_val;
                    CFG_DST_H: r_th <= cfg_val;
                    default:   r_sw <= r_sw;
                endcase
            end
            if (i_cmd.take_load) begin
                r_lc <= ld_next;
            end
            if (i_cmd.take_pixel) begin
                if (row_end_now) begin
                    r_oc  <= '0;
                    r_sc  <= '0;
                    r_acc <= '0;
                    r_lc  <= '0;
                    r_or  <= frame_now ? '0 : r_or + 1'b1;
                end else begin
                    r_oc <= r_oc + 1'b1;
                end
            end
            if (i_cmd.col_apply) begin
                r_acc <= div_rem;
                r_sc  <= sc_next;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_load) begin
            mem[to_idx(ld_col)] <= i_alpha_byte;
        end
        if (i_cmd.take_pixel) begin
            r_alpha <= mem[to_idx(rd_col)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_pixel) begin
            r_row_end   <= row_end_now;
            r_frame_end <= frame_now;
            r_cv_r      <= cvt_scale(i_red_bits);
            r_cv_g      <= cvt_scale(i_green_bits);
            r_cv_b      <= cvt_scale(i_blue_bits);
        end
        r_by_r <= cvt_round(r_cv_r);
        r_by_g <= cvt_round(r_cv_g);
        r_by_b <= cvt_round(r_cv_b);
        if (i_cmd.row_mul) begin
            r_prod <= r_or * r_sh;
        end
        if (i_cmd.out_load) begin
            r_o_r   <= r_by_r;
            r_o_g   <= r_by_g;
            r_o_b   <= r_by_b;
            r_o_a   <= r_alpha;
            r_o_re  <= r_row_end;
            r_o_fe  <= r_frame_end;
            r_o_nir <= nir_full[ROW_W-1:0];
        end
    end

    assign o_sts.row_end_now = row_end_now;
    assign o_sts.div_busy    = div_busy;
    assign o_sts.out_free    = out_free;

    assign o_valid          = r_ovalid;
    assign o_red_byte       = r_o_r;
    assign o_green_byte     = r_o_g;
    assign o_blue_byte      = r_o_b;
    assign o_alpha_out      = r_o_a;
    assign o_row_end        = r_o_re;
    assign o_frame_end      = r_o_fe;
    assign o_next_input_row = r_o_nir;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("output register loaded while occupied");

    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> div_busy)
        else $error("divider did not start");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(i_cmd.out_load))
        else $error("result valid without load");

endmodule

// ===== rtl/core/frapk_ctrl.sv =====
// ----------------------------------------------------------------------------
// frapk_ctrl
// Sequencer: accepts requests and steps the datapath through the column (not at a row end) and row divisions.
// ----------------------------------------------------------------------------
module frapk_ctrl
    import frapk_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_action,
    input  t_sts i_sts,
    output logic o_stall,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid && i_action) begin
                    n_state = i_sts.row_end_now ? ST_ROW_MUL : ST_COL_GO;
                end
            end
            ST_COL_GO:   n_state = ST_COL_WAIT;
            ST_COL_WAIT: begin
                if (!i_sts.div_busy) begin
                    n_state = ST_ROW_MUL;
                end
            end
            ST_ROW_MUL:  n_state = ST_ROW_GO;
            ST_ROW_GO:   n_state = ST_ROW_WAIT;
            ST_ROW_WAIT: begin
                if (!i_sts.div_busy && i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall          = 1'b0;
                o_cmd.take_load  = i_valid && !i_action;
                o_cmd.take_pixel = i_valid && i_action;
            end
            ST_COL_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_COL;
            end
            ST_COL_WAIT: o_cmd.col_apply = !i_sts.div_busy;
            ST_ROW_MUL:  o_cmd.row_mul = 1'b1;
            ST_ROW_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_ROW;
            end
            ST_ROW_WAIT: o_cmd.out_load = !i_sts.div_busy && i_sts.out_free;
            default:     o_stall = 1'b1;
        endcase
    end

endmodule

// ===== rtl/core/float_rgb_alpha_resample_packer.sv =====
// ----------------------------------------------------------------------------
// float_rgb_alpha_resample_packer
// Float RGB to byte conversion with nearest-neighbor alpha from a row memory.
// ----------------------------------------------------------------------------
// Alpha load request: taken in the idle state without stalling. Pixel request:
// column division, then row division, before o_valid; the column division is
// skipped on the last pixel of a row. One pixel in flight at a time.
// The result register frees the input side while a result waits.
// Synchronous active-low reset clears counters and sets all sizes to 1;
// the alpha memory is not cleared.
// ----------------------------------------------------------------------------
module float_rgb_alpha_resample_packer
    import frapk_pkg::*;
#(
    parameter int MAX_DIM = 4096
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_action,
    input  logic [BYTE_W-1:0] i_alpha_byte,
    input  logic [31:0]       i_red_bits,
    input  logic [31:0]       i_green_bits,
    input  logic [31:0]       i_blue_bits,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_red_byte,
    output logic [BYTE_W-1:0] o_green_byte,
    output logic [BYTE_W-1:0] o_blue_byte,
    output logic [BYTE_W-1:0] o_alpha_out,
    output logic              o_row_end,
    output logic              o_frame_end,
    output logic [ROW_W-1:0]  o_next_input_row,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]  i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    frapk_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .i_sts    (sts),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    frapk_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_alpha_byte     (i_alpha_byte),
        .i_red_bits       (i_red_bits),
        .i_green_bits     (i_green_bits),
        .i_blue_bits      (i_blue_bits),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_red_byte       (o_red_byte),
        .o_green_byte     (o_green_byte),
        .o_blue_byte      (o_blue_byte),
        .o_alpha_out      (o_alpha_out),
        .o_row_end        (o_row_end),
        .o_frame_end      (o_frame_end),
        .o_next_input_row (o_next_input_row)
    );

endmodule

// ===== verif/float_rgb_alpha_resample_packer_checker.sv =====
// ----------------------------------------------------------------------------
// float_rgb_alpha_resample_packer_checker
// Watches the request, result and register channels of the RGBA packer. It
// keeps its own copy of the sizes, counters and alpha row, predicts each
// packed pixel, and compares every result field with the oldest prediction.
// ----------------------------------------------------------------------------
module float_rgb_alpha_resample_packer_checker
    import frapk_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_in_stall,
    input  logic              i_action,
    input  logic [BYTE_W-1:0] i_alpha_byte,
    input  logic [31:0]       i_red_bits,
    input  logic [31:0]       i_green_bits,
    input  logic [31:0]       i_blue_bits,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [BYTE_W-1:0] i_red_byte,
    input  logic [BYTE_W-1:0] i_green_byte,
    input  logic [BYTE_W-1:0] i_blue_byte,
    input  logic [BYTE_W-1:0] i_alpha_out,
    input  logic              i_row_end,
    input  logic              i_frame_end,
    input  logic [ROW_W-1:0]  i_next_input_row,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]  i_cfg_data,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_pixel_count,
    output int unsigned       o_out_col,
    output int unsigned       o_out_row
);

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        row_end;
        logic        frame_end;
        logic [11:0] next_row;
    } t_pixel;

    t_pixel      pixel_q[$];
    logic [7:0]  alpha_store[4096];
    int unsigned src_w, src_h, dst_w, dst_h;
    int unsigned load_col, out_col, out_row, src_col, step_acc;

    assign o_out_col = out_col;
    assign o_out_row = out_row;

    function automatic logic [63:0] round_even(input logic [63:0] v, input int d);
        logic [63:0] keep;
        logic [63:0] low;
        logic [63:0] half;
        keep = v >> d;
        low  = v & ((64'd1 << d) - 64'd1);
        half = 64'd1 << (d - 1);
        if (low > half || (low == half && keep[0])) begin
            keep = keep + 64'd1;
        end
        return keep;
    endfunction

    // exact single-precision value*255 then +0.5, truncated
    function automatic logic [7:0] unorm8(input logic [31:0] f);
        logic [7:0]  e;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] y;
        int          d;
        int          n;
        e = f[30:23];
        if (f[31] || f[30:0] == 31'd0 || (e == 8'hFF && f[22:0] != 23'd0)) return 8'd0;
        if (e >= 8'd127) return 8'd255;
        if (e < 8'd100) return 8'd0;
        p = {40'd0, 1'b1, f[22:0]} * 64'd255;
        d = p[31] ? 8 : 7;
        s = round_even(p, d);
        y = (s << (int'(e) - 102 + d)) + (64'd1 << 47);
        n = 0;
        for (int k = 0; k < 64; k++) begin
            if (y[k]) n = k;
        end
        y = round_even(y, n - 23) << (n - 23);
        return y[55:48];
    endfunction

    function automatic int unsigned clamp_size(input logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (v > 13'd4096) return 4096;
        return int'(v);
    endfunction

    function automatic int unsigned lesser(input int unsigned a, input int unsigned b);
        return a < b ? a : b;
    endfunction

    task automatic pack_pixel(input logic [31:0] r, input logic [31:0] g,
                              input logic [31:0] b);
        t_pixel      px;
        int unsigned col;
        int unsigned steps;
        longint unsigned row_sel;
        col          = lesser(src_col, src_w - 1);
        px.alpha     = alpha_store[col];
        px.row_end   = out_col >= dst_w - 1;
        px.frame_end = px.row_end && out_row >= dst_h - 1;
        if (px.row_end) begin
            out_col  = 0;
            src_col  = 0;
            step_acc = 0;
            load_col = 0;
            out_row  = px.frame_end ? 0 : out_row + 1;
        end else begin
            out_col  = out_col + 1;
            step_acc = step_acc + src_w;
            steps    = step_acc / dst_w;
            step_acc = step_acc - steps * dst_w;
            src_col  = lesser(src_col + steps, src_w - 1);
        end
        row_sel     = (longint'(out_row) * src_h) / dst_h;
        if (row_sel > src_h - 1) row_sel = src_h - 1;
        px.red      = unorm8(r);
        px.green    = unorm8(g);
        px.blue     = unorm8(b);
        px.next_row = row_sel[11:0];
        pixel_q.push_back(px);
    endtask

    task automatic compare(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel      px;
        int unsigned col;
        if (!i_rst_n) begin
            pixel_q.delete();
            src_w    = 1;
            src_h    = 1;
            dst_w    = 1;
            dst_h    = 1;
            load_col = 0;
            out_col  = 0;
            out_row  = 0;
            src_col  = 0;
            step_acc = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pixel_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result, expected none, got rgba %h%h%h%h",
                             $time, i_red_byte, i_green_byte, i_blue_byte, i_alpha_out);
                end else begin
                    px = pixel_q.pop_front();
                    compare("red_byte", px.red, i_red_byte);
                    compare("green_byte", px.green, i_green_byte);
                    compare("blue_byte", px.blue, i_blue_byte);
                    compare("alpha_out", px.alpha, i_alpha_out);
                    compare("row_end", px.row_end, i_row_end);
                    compare("frame_end", px.frame_end, i_frame_end);
                    compare("next_input_row", px.next_row, i_next_input_row);
                    o_pixel_count++;
                end
            end
            if (i_valid && !i_in_stall) begin
                if (i_action) begin
                    pack_pixel(i_red_bits, i_green_bits, i_blue_bits);
                end else begin
                    col              = lesser(load_col, src_w - 1);
                    alpha_store[col] = i_alpha_byte;
                    load_col         = lesser(col + 1, src_w - 1);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SRC_W: src_w = clamp_size(i_cfg_data);
                    CFG_SRC_H: src_h = clamp_size(i_cfg_data);
                    CFG_DST_W: dst_w = clamp_size(i_cfg_data);
                    CFG_DST_H: dst_h = clamp_size(i_cfg_data);
                endcase
            end
        end
        o_pending = pixel_q.size();
    end

    initial begin
        o_fail_count  = 0;
        o_pixel_count = 0;
        o_pending     = 0;
    end

endmodule

// ===== verif/float_rgb_alpha_resample_packer_test.sv =====
// ----------------------------------------------------------------------------
// float_rgb_alpha_resample_packer_test
// Drives alpha loads, float pixels and size writes into the RGBA packer with
// random gaps on both channels, over a directed opening and random frames.
// ----------------------------------------------------------------------------
module float_rgb_alpha_resample_packer_test;
    import frapk_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_action = 1'b0;
    logic [BYTE_W-1:0] i_alpha_byte = '0;
    logic [31:0]       i_red_bits = '0;
    logic [31:0]       i_green_bits = '0;
    logic [31:0]       i_blue_bits = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [BYTE_W-1:0] o_red_byte;
    logic [BYTE_W-1:0] o_green_byte;
    logic [BYTE_W-1:0] o_blue_byte;
    logic [BYTE_W-1:0] o_alpha_out;
    logic              o_row_end;
    logic              o_frame_end;
    logic [ROW_W-1:0]  o_next_input_row;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index = '0;
    logic [DIM_W-1:0]  i_cfg_data = '0;

    int          fail_count, pending, pixel_count;
    int unsigned pred_col, pred_row;
    int          tx_idle, rx_idle;
    int          loads_sent, frames_sent;
    int unsigned src_w, src_h, dst_w, dst_h, written_w;

    float_rgb_alpha_resample_packer dut (.*);

    float_rgb_alpha_resample_packer_checker u_checker (
        .i_clk, .i_rst_n, .i_valid,
        .i_in_stall(o_stall),
        .i_action, .i_alpha_byte, .i_red_bits, .i_green_bits, .i_blue_bits,
        .i_out_valid(o_valid),
        .i_out_stall(i_stall),
        .i_red_byte(o_red_byte),
        .i_green_byte(o_green_byte),
        .i_blue_byte(o_blue_byte),
        .i_alpha_out(o_alpha_out),
        .i_row_end(o_row_end),
        .i_frame_end(o_frame_end),
        .i_next_input_row(o_next_input_row),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count),
        .o_pending(pending),
        .o_pixel_count(pixel_count),
        .o_out_col(pred_col),
        .o_out_row(pred_row)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle);
        end
    end

    function automatic int unsigned eff_size(input logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (v > 13'd4096) return 4096;
        return int'(v);
    endfunction

    task automatic send_request(input logic act, input logic [7:0] alpha,
                                input logic [31:0] r, input logic [31:0] g,
                                input logic [31:0] b);
        logic ok;
        while ($urandom_range(99) < tx_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= act;
        i_alpha_byte <= alpha;
        i_red_bits   <= r;
        i_green_bits <= g;
        i_blue_bits  <= b;
        do begin
            @(negedge i_clk);
            ok = !o_stall;
            @(posedge i_clk);
        end while (!ok);
        if (!act) loads_sent++;
    endtask

    function automatic logic [31:0] colour_bits();
        case ($urandom_range(11))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return 32'h3F80_0000;
            3: return 32'h3F7F_FFFF;
            4: return {1'b0, 8'hFF, 23'd0};
            5: return {1'b1, 8'hFF, 23'd0};
            6: return {1'($urandom_range(1)), 8'hFF, 23'($urandom) | 23'd1};
            7: return {1'b0, 8'd0, 23'($urandom)};
            8: return $urandom;
            default: return {1'b0, 8'($urandom_range(126, 117)), 23'($urandom)};
        endcase
    endfunction

    task automatic send_pixel();
        send_request(1'b1, 8'($urandom), colour_bits(), colour_bits(), colour_bits());
    endtask

    task automatic send_load(input logic [7:0] alpha);
        send_request(1'b0, alpha, $urandom, $urandom, $urandom);
    endtask

    // hold until every result is in, then let the block settle
    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [DIM_W-1:0] data);
        logic ok;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(negedge i_clk);
            ok = o_cfg_ready;
            @(posedge i_clk);
        end while (!ok);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SRC_W: src_w = eff_size(data);
            CFG_SRC_H: src_h = eff_size(data);
            CFG_DST_W: dst_w = eff_size(data);
            CFG_DST_H: dst_h = eff_size(data);
        endcase
    endtask

    function automatic logic [DIM_W-1:0] size_code(input int unsigned v);
        if (v == 1 && $urandom_range(3) == 0) return '0;
        if (v == 4096 && $urandom_range(1) == 0) return 13'(4096 + $urandom_range(4095));
        return DIM_W'(v);
    endfunction

    // advance to the start of a frame
    task automatic finish_frame();
        @(negedge i_clk);
        while (pred_col != 0 || pred_row != 0) begin
            @(posedge i_clk);
            send_pixel();
            @(negedge i_clk);
        end
    endtask

    task automatic play_frame();
        int cnt;
        for (int unsigned row = 0; row < dst_h; row++) begin
            cnt = src_w;
            if (written_w >= src_w && $urandom_range(4) == 0) cnt = $urandom_range(src_w);
            else if ($urandom_range(5) == 0) cnt = src_w + $urandom_range(3, 1);
            for (int k = 0; k < cnt; k++) send_load(8'($urandom));
            if (cnt >= src_w && written_w < src_w) written_w = src_w;
            for (int unsigned c = 0; c < dst_w; c++) begin
                if (written_w >= src_w && $urandom_range(15) == 0) send_load(8'($urandom));
                send_pixel();
            end
        end
        frames_sent++;
    endtask

    task automatic random_phase(input int tx, input int rx, input int budget,
                                input bit wide_row);
        int start;
        tx_idle = tx;
        rx_idle = rx;
        start   = pixel_count;
        while (pixel_count + pending - start < budget) begin
            drain();
            write_reg(CFG_SRC_W, size_code($urandom_range(16, 1)));
            write_reg(CFG_SRC_H, size_code($urandom_range(7) == 0 ? 4096 : $urandom_range(16, 1)));
            write_reg(CFG_DST_W, size_code($urandom_range(12, 1)));
            write_reg(CFG_DST_H,
                      size_code(src_h == 4096 ? $urandom_range(3, 1) : $urandom_range(6, 1)));
            play_frame();
            if ($urandom_range(9) == 0) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
                while (pending != 0) @(negedge i_clk);
                @(posedge i_clk);
            end
        end
        if (wide_row) begin
            drain();
            write_reg(CFG_SRC_W, 13'd3);
            write_reg(CFG_DST_W, 13'd300);
            write_reg(CFG_DST_H, 13'd1);
            play_frame();
        end
    endtask

    initial begin
        tx_idle     = 0;
        rx_idle     = 0;
        loads_sent  = 0;
        frames_sent = 0;
        src_w       = 1;
        src_h       = 1;
        dst_w       = 1;
        dst_h       = 1;
        written_w   = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle = 20;
        rx_idle = 20;
        write_reg(CFG_SRC_W, 13'd4);
        write_reg(CFG_SRC_H, 13'd3);
        write_reg(CFG_DST_W, 13'd3);
        write_reg(CFG_DST_H, 13'd2);
        send_load(8'h00);
        send_load(8'hFF);
        send_load(8'h5A);
        send_load(8'hA5);
        written_w = 4;
        send_request(1'b1, 8'h00, 32'h0000_0000, 32'h8000_0000, 32'h3F80_0000);
        send_request(1'b1, 8'hFF, 32'h7FC0_0001, 32'h7F80_0000, 32'h3F00_0000);
        send_request(1'b1, 8'h00, 32'h3F7F_FFFF, 32'h0000_0001, 32'h3B00_0000);
        for (int k = 0; k < 6; k++) send_load(8'(8'h10 + k));
        send_request(1'b1, 8'hFF, 32'hFFFF_FFFF, 32'h3E80_0000, 32'h3C00_0000);
        send_request(1'b1, 8'h00, 32'h3C00_8081, 32'hBF80_0000, 32'h4F00_0000);
        send_request(1'b1, 8'hFF, 32'h3F7F_8000, 32'h3A80_0000, 32'h0080_0000);
        drain();
        write_reg(CFG_DST_W, 13'd0);
        write_reg(CFG_DST_H, 13'h1FFF);
        write_reg(CFG_SRC_H, 13'd4096);
        repeat (3) send_pixel();
        drain();
        write_reg(CFG_DST_H, 13'd1);
        write_reg(CFG_SRC_W, 13'd2);
        send_pixel();
        finish_frame();

        random_phase(30, 52, 200, 1'b0);
        random_phase(52, 30, 200, 1'b0);
        random_phase(0, 0, 200, 1'b1);

        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Checked %0d packed pixels over %0d frames, with %0d alpha loads.",
                 pixel_count, frames_sent, loads_sent);
        $display("Widths up to 16 plus a 300-pixel row, heights up to 4096, gaps in three phases.");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
